@@ rtl/core/bsc_pkg.sv @@
// Shared constants and types for the barometric sensor compensation block.
package bsc_pkg;

   localparam int unsigned DATA_W   = 64;
   localparam int unsigned RAW_W    = 20;
   localparam int unsigned RES_W    = 32;
   localparam int unsigned CSR_IDX_W = 2;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_CAL       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_CAL_LOW  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_CAL_HIGH = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_CAL_LAST = 2'd3;

   // Commands
   localparam logic CMD_TEMP  = 1'b0;
   localparam logic CMD_PRESS = 1'b1;

   // Formula constants
   localparam logic [63:0] FINE_OFFSET = 64'd128000;
   localparam logic [63:0] PRESS_BASE  = 64'd1048576;
   localparam logic [63:0] DIV_SCALE   = 64'd3125;
   localparam logic [31:0] TEMP_ROUND  = 32'd128;

   // Request to a shared arithmetic unit
   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] opa;
      logic [DATA_W-1:0] opb;
   } arith_req_type;

   // Answer from a shared arithmetic unit
   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] result;
   } arith_rsp_type;

endpackage

@@ rtl/core/bsc_if.sv @@
// Handshake channels: sample item in, compensated item out.
interface bsc_req_if;
   import bsc_pkg::*;
   logic             valid;
   logic             ready;
   logic             command;
   logic [RAW_W-1:0] raw_sample;
   modport source (output valid, command, raw_sample, input ready);
   modport sink   (input valid, command, raw_sample, output ready);
endinterface

interface bsc_rsp_if;
   import bsc_pkg::*;
   logic             valid;
   logic             ready;
   logic [RES_W-1:0] temperature_centi;
   logic [RES_W-1:0] pressure_q24_8;
   logic             zero_divisor;
   modport source (output valid, temperature_centi, pressure_q24_8, zero_divisor,
                   input ready);
   modport sink   (input valid, temperature_centi, pressure_q24_8, zero_divisor,
                   output ready);
endinterface

@@ rtl/core/bsc_mul.sv @@
// Multi-cycle multiplier: low 64 bits of a 64x64 product from 32x32 partial products.
module bsc_mul (
   input  logic                   clock,
   input  logic                   reset,
   input  bsc_pkg::arith_req_type req_in,
   output bsc_pkg::arith_rsp_type rsp_out
);
   import bsc_pkg::*;

   logic [63:0] a_ff, b_ff, acc_ff, pp_ff, pp_in;
   logic [1:0]  cnt_ff;
   logic        busy_ff, done_ff;
   logic [31:0] pa, pb;

   // Partial product pick: lo*lo, lo*hi, hi*lo
   always_comb begin
      unique case (cnt_ff)
         2'd0: begin pa = a_ff[31:0];  pb = b_ff[31:0];  end
         2'd1: begin pa = a_ff[31:0];  pb = b_ff[63:32]; end
         2'd2: begin pa = a_ff[63:32]; pb = b_ff[31:0];  end
         default: begin pa = '0; pb = '0; end
      endcase
      pp_in = pa * pb;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req_in.start) begin
            a_ff    <= req_in.opa;
            b_ff    <= req_in.opb;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            pp_ff  <= pp_in;
            cnt_ff <= cnt_ff + 2'd1;
            // accumulate the partial product of the previous cycle
            if (cnt_ff == 2'd1) begin
               acc_ff <= pp_ff;
            end else if (cnt_ff != 2'd0) begin
               acc_ff <= acc_ff + {pp_ff[31:0], 32'b0};
            end
            if (cnt_ff == 2'd3) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp_out.done   = done_ff;
   assign rsp_out.result = acc_ff;

endmodule

@@ rtl/core/bsc_div.sv @@
// Radix-2 restoring signed 64-bit divider, truncating toward zero.
module bsc_div (
   input  logic                   clock,
   input  logic                   reset,
   input  bsc_pkg::arith_req_type req_in,
   output bsc_pkg::arith_rsp_type rsp_out
);
   import bsc_pkg::*;

   logic [63:0] rem_ff, quo_ff, md_ff, res_ff;
   logic [6:0]  cnt_ff;
   logic        neg_ff, busy_ff, done_ff;
   logic [64:0] rem_sh, diff;

   // One quotient bit per cycle
   always_comb begin
      rem_sh = {rem_ff, quo_ff[63]};
      diff   = rem_sh - {1'b0, md_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req_in.start) begin
            neg_ff  <= req_in.opa[63] ^ req_in.opb[63];
            quo_ff  <= req_in.opa[63] ? (64'd0 - req_in.opa) : req_in.opa;
            md_ff   <= req_in.opb[63] ? (64'd0 - req_in.opb) : req_in.opb;
            rem_ff  <= '0;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (cnt_ff == 7'd64) begin
               res_ff  <= neg_ff ? (64'd0 - quo_ff) : quo_ff;
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff + 7'd1;
               if (!diff[64]) begin
                  rem_ff <= diff[63:0];
                  quo_ff <= {quo_ff[62:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh[63:0];
                  quo_ff <= {quo_ff[62:0], 1'b0};
               end
            end
         end
      end
   end

   assign rsp_out.done   = done_ff;
   assign rsp_out.result = res_ff;

endmodule

@@ rtl/core/barometric_sensor_compensation.sv @@
// Top level: sequencer driving a shared multiplier and divider for sensor compensation.
//
//  - req channel carries one item: command (0 temperature, 1 pressure) and a
//    20-bit raw sample. req.ready is high only while the block is idle.
//  - rsp channel returns exactly one item per request: temperature in
//    hundredths of a degree, pressure as Q24.8 Pa, and a zero-divisor flag.
//  - Each multiply runs through an issue state, then the partial-product steps and the
//    done register of the shared 32x32 multiplier. The divide runs through issue,
//    64 quotient bits, sign fix-up and done.
//  - From accept to rsp.valid, temperature takes 3 multiplies, pressure 10 multiplies
//    and the divide, zero divisor 6 multiplies. The block is ready for the next item
//    as soon as the result is offered, and it works on one item at a time.
//  - The stored fine temperature is updated by each temperature item and
//    used by each following pressure item.
//  - Users must write calibration words via the csr port only while idle (unchecked).
//  - Reset clears calibration words, the fine temperature and all control.
//  - When the receiver stalls, the finished item sits in the output register;
//    a new item can be accepted meanwhile but waits at its end until the
//    previous result is taken.
module barometric_sensor_compensation (
   input  logic                             clock,
   input  logic                             reset,
   bsc_req_if.sink                          req,
   bsc_rsp_if.source                        rsp,
   input  logic                             csr_write_en,
   input  logic [bsc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bsc_pkg::DATA_W-1:0]       csr_data
);
   import bsc_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_ISSUE, S_WAIT, S_DIV_ISSUE, S_DIV_WAIT, S_FINISH
   } state_type;

   typedef enum logic [3:0] {
      OP_T0, OP_T1, OP_T2,
      OP_P0, OP_P1, OP_P2, OP_P3, OP_P4, OP_P5, OP_P6, OP_P7, OP_P8, OP_P9
   } step_type;

   state_type state_ff;
   step_type  step_ff;

   logic [47:0] tcal_ff;
   logic [63:0] pcal_lo_ff, pcal_hi_ff;
   logic [15:0] pcal_last_ff;
   logic [31:0] fine_ff;
   logic [63:0] x_ff, y_ff, z_ff;
   logic        cmd_ff, zero_ff;
   logic [19:0] adc_ff;
   logic        rsp_valid_ff, rsp_zero_ff;
   logic [31:0] rsp_temp_ff, rsp_press_ff;
   logic        hand_over;

   arith_req_type mul_req, div_req;
   arith_rsp_type mul_rsp, div_rsp;

   // Calibration words, sign-extended where signed
   logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
   assign t1 = {48'b0, tcal_ff[15:0]};
   assign t2 = {{48{tcal_ff[31]}}, tcal_ff[31:16]};
   assign t3 = {{48{tcal_ff[47]}}, tcal_ff[47:32]};
   assign p1 = {48'b0, pcal_lo_ff[15:0]};
   assign p2 = {{48{pcal_lo_ff[31]}}, pcal_lo_ff[31:16]};
   assign p3 = {{48{pcal_lo_ff[47]}}, pcal_lo_ff[47:32]};
   assign p4 = {{48{pcal_lo_ff[63]}}, pcal_lo_ff[63:48]};
   assign p5 = {{48{pcal_hi_ff[15]}}, pcal_hi_ff[15:0]};
   assign p6 = {{48{pcal_hi_ff[31]}}, pcal_hi_ff[31:16]};
   assign p7 = {{48{pcal_hi_ff[47]}}, pcal_hi_ff[47:32]};
   assign p8 = {{48{pcal_hi_ff[63]}}, pcal_hi_ff[63:48]};
   assign p9 = {{48{pcal_last_ff[15]}}, pcal_last_ff};

   // Temperature differences, 32-bit wrap
   logic [31:0] ta, tb;
   assign ta = {15'b0, adc_ff[19:3]} - {t1[30:0], 1'b0};
   assign tb = {16'b0, adc_ff[19:4]} - t1[31:0];

   logic [63:0] q_sh, press_p;
   assign q_sh    = $signed(x_ff) >>> 13;
   assign press_p = PRESS_BASE - {44'b0, adc_ff};

   // Operand select for the shared multiplier
   always_comb begin
      mul_req.start = (state_ff == S_ISSUE);
      unique case (step_ff)
         OP_T0: begin mul_req.opa = {{32{ta[31]}}, ta}; mul_req.opb = t2; end
         OP_T1: begin mul_req.opa = {{32{tb[31]}}, tb}; mul_req.opb = {{32{tb[31]}}, tb}; end
         OP_T2: begin mul_req.opa = y_ff; mul_req.opb = t3; end
         OP_P0: begin mul_req.opa = x_ff; mul_req.opb = x_ff; end
         OP_P1: begin mul_req.opa = y_ff; mul_req.opb = p6; end
         OP_P2: begin mul_req.opa = x_ff; mul_req.opb = p5; end
         OP_P3: begin mul_req.opa = y_ff; mul_req.opb = p3; end
         OP_P4: begin mul_req.opa = x_ff; mul_req.opb = p2; end
         OP_P5: begin mul_req.opa = y_ff + (64'd1 << 47); mul_req.opb = p1; end
         OP_P6: begin mul_req.opa = (press_p << 31) - z_ff; mul_req.opb = DIV_SCALE; end
         OP_P7: begin mul_req.opa = p9; mul_req.opb = q_sh; end
         OP_P8: begin mul_req.opa = y_ff; mul_req.opb = q_sh; end
         default: begin mul_req.opa = x_ff; mul_req.opb = p8; end
      endcase
      div_req.start = (state_ff == S_DIV_ISSUE);
      div_req.opa   = x_ff;
      div_req.opb   = y_ff;
   end

   bsc_mul u_mul (.clock(clock), .reset(reset), .req_in(mul_req), .rsp_out(mul_rsp));
   bsc_div u_div (.clock(clock), .reset(reset), .req_in(div_req), .rsp_out(div_rsp));

   // Writeback shapes of the product
   logic [63:0] prod;
   logic [31:0] prod32, asr11, asr12, asr14;
   logic [63:0] asr8, asr19, asr25, asr33;
   assign prod   = mul_rsp.result;
   assign prod32 = prod[31:0];
   assign asr11  = $signed(prod32) >>> 11;
   assign asr12  = $signed(prod32) >>> 12;
   assign asr14  = $signed(prod32) >>> 14;
   assign asr8   = $signed(prod) >>> 8;
   assign asr19  = $signed(prod) >>> 19;
   assign asr25  = $signed(prod) >>> 25;
   assign asr33  = $signed(prod) >>> 33;

   // Final shaping of both results
   logic [31:0] temp5, temp_res;
   logic [63:0] psum, psum_sh, press_res;
   assign temp5     = (fine_ff << 2) + fine_ff + TEMP_ROUND;
   assign temp_res  = $signed(temp5) >>> 8;
   assign psum      = x_ff + z_ff;
   assign psum_sh   = $signed(psum) >>> 8;
   assign press_res = psum_sh + (p7 << 4);

   // finished item moves to the output register once it is free
   assign hand_over = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp.ready);

   // Sequencer, working registers and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= OP_T0;
         rsp_valid_ff <= 1'b0;
         fine_ff      <= '0;
         tcal_ff      <= '0;
         pcal_lo_ff   <= '0;
         pcal_hi_ff   <= '0;
         pcal_last_ff <= '0;
      end else begin
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_TEMP_CAL:       tcal_ff      <= csr_data[47:0];
               CSR_PRESS_CAL_LOW:  pcal_lo_ff   <= csr_data;
               CSR_PRESS_CAL_HIGH: pcal_hi_ff   <= csr_data;
               default:            pcal_last_ff <= csr_data[15:0];
            endcase
         end
         if (hand_over) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req.valid) begin
                  cmd_ff   <= req.command;
                  adc_ff   <= req.raw_sample;
                  zero_ff  <= 1'b0;
                  x_ff     <= {{32{fine_ff[31]}}, fine_ff} - FINE_OFFSET;
                  step_ff  <= (req.command == CMD_PRESS) ? OP_P0 : OP_T0;
                  state_ff <= S_ISSUE;
               end
            end
            S_ISSUE: state_ff <= S_WAIT;
            S_WAIT: begin
               if (mul_rsp.done) begin
                  unique case (step_ff)
                     OP_T0: begin
                        x_ff     <= {32'b0, asr11};
                        step_ff  <= OP_T1;
                        state_ff <= S_ISSUE;
                     end
                     OP_T1: begin
                        y_ff     <= {{32{asr12[31]}}, asr12};
                        step_ff  <= OP_T2;
                        state_ff <= S_ISSUE;
                     end
                     OP_T2: begin
                        fine_ff  <= x_ff[31:0] + asr14;
                        state_ff <= S_FINISH;
                     end
                     OP_P0: begin y_ff <= prod; step_ff <= OP_P1; state_ff <= S_ISSUE; end
                     OP_P1: begin z_ff <= prod; step_ff <= OP_P2; state_ff <= S_ISSUE; end
                     OP_P2: begin
                        z_ff     <= z_ff + (prod << 17) + (p4 << 35);
                        step_ff  <= OP_P3;
                        state_ff <= S_ISSUE;
                     end
                     OP_P3: begin y_ff <= asr8; step_ff <= OP_P4; state_ff <= S_ISSUE; end
                     OP_P4: begin
                        y_ff     <= y_ff + (prod << 12);
                        step_ff  <= OP_P5;
                        state_ff <= S_ISSUE;
                     end
                     OP_P5: begin
                        y_ff    <= asr33;
                        step_ff <= OP_P6;
                        if (asr33 == 64'd0) begin
                           zero_ff  <= 1'b1;
                           state_ff <= S_FINISH;
                        end else begin
                           state_ff <= S_ISSUE;
                        end
                     end
                     OP_P6: begin x_ff <= prod; state_ff <= S_DIV_ISSUE; end
                     OP_P7: begin y_ff <= prod; step_ff <= OP_P8; state_ff <= S_ISSUE; end
                     OP_P8: begin y_ff <= asr25; step_ff <= OP_P9; state_ff <= S_ISSUE; end
                     default: begin
                        z_ff     <= asr19 + y_ff;
                        state_ff <= S_FINISH;
                     end
                  endcase
               end
            end
            S_DIV_ISSUE: state_ff <= S_DIV_WAIT;
            S_DIV_WAIT: begin
               if (div_rsp.done) begin
                  x_ff     <= div_rsp.result;
                  step_ff  <= OP_P7;
                  state_ff <= S_ISSUE;
               end
            end
            default: begin
               // hand the item over once the output register is free
               if (hand_over) begin
                  rsp_zero_ff  <= zero_ff;
                  rsp_temp_ff  <= (cmd_ff == CMD_TEMP) ? temp_res : 32'd0;
                  rsp_press_ff <= (cmd_ff == CMD_PRESS && !zero_ff) ?
                                  press_res[31:0] : 32'd0;
                  state_ff     <= S_IDLE;
               end
            end
         endcase
      end
   end

   assign req.ready             = (state_ff == S_IDLE);
   assign rsp.valid             = rsp_valid_ff;
   assign rsp.temperature_centi = rsp_temp_ff;
   assign rsp.pressure_q24_8    = rsp_press_ff;
   assign rsp.zero_divisor      = rsp_zero_ff;

   // Checks
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> !req.ready)
      else $error("block still ready after taking an item");
   a_zero_clears_values: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.zero_divisor |-> rsp.pressure_q24_8 == 32'd0
         && rsp.temperature_centi == 32'd0)
      else $error("zero divisor item carries nonzero values");
   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.temperature_centi != 32'd0 |-> rsp.pressure_q24_8 == 32'd0)
      else $error("item carries both temperature and pressure");
   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(mul_rsp.done && div_rsp.done))
      else $error("multiplier and divider finished together");

endmodule

@@ tb/barometric_sensor_compensation_tb.sv @@
// Self-checking testbench for the barometric sensor compensation block.
module barometric_sensor_compensation_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bsc_pkg::*;

   typedef struct packed {
      logic signed [31:0] temperature_centi;
      logic [31:0]        pressure_q24_8;
      logic               zero_divisor;
   } comp_result_type;

   typedef struct packed {
      logic                 is_cfg;
      logic [CSR_IDX_W-1:0] idx;
      logic [DATA_W-1:0]    data;
      logic                 command;
      logic [RAW_W-1:0]     raw;
      logic                 has_known;
      comp_result_type      known;
   } stim_row_type;

   localparam logic [47:0] TEMP_CAL_TYPICAL = {16'hFC18, 16'd26435, 16'd27504};
   localparam logic [63:0] PCAL_LOW_TYPICAL = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
   localparam logic [63:0] PCAL_HIGH_TYPICAL = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
   localparam logic [15:0] PCAL_LAST_TYPICAL = 16'd6000;
   localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_TEMP_CAL;
   logic [DATA_W-1:0]    csr_data = '0;

   bsc_req_if req_ch ();
   bsc_rsp_if rsp_ch ();

   barometric_sensor_compensation dut (
      .clock        (clock),
      .reset        (reset),
      .req          (req_ch),
      .rsp          (rsp_ch),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   // Predictor copy of calibration and fine temperature
   logic [47:0]        temp_cal;
   logic [63:0]        press_cal_low;
   logic [63:0]        press_cal_high;
   logic [15:0]        press_cal_last;
   logic signed [31:0] fine_temp;

   comp_result_type expected_results[$];
   int  mismatches = 0;
   bit  idle_tx = 1'b1;
   bit  idle_rx = 1'b1;
   stim_row_type directed_rows[$];

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("barometric_sensor_compensation_tb: FAIL");
      $finish;
   end

   // Temperature compensation, 32-bit wrapping arithmetic
   function automatic comp_result_type compensate_temp(logic [RAW_W-1:0] raw);
      comp_result_type r;
      logic [31:0] t1, a, b;
      logic signed [31:0] t2, t3, v1, v2, sq;
      t1 = {16'd0, temp_cal[15:0]};
      t2 = 32'($signed(temp_cal[31:16]));
      t3 = 32'($signed(temp_cal[47:32]));
      a = ({12'd0, raw} >> 3) - (t1 << 1);
      v1 = $signed(a * t2) >>> 11;
      b = ({12'd0, raw} >> 4) - t1;
      sq = $signed(b * b) >>> 12;
      v2 = $signed(sq * t3) >>> 14;
      fine_temp = v1 + v2;
      r.temperature_centi = $signed(fine_temp * 32'sd5 + 32'sd128) >>> 8;
      r.pressure_q24_8 = '0;
      r.zero_divisor = 1'b0;
      return r;
   endfunction

   // Pressure compensation, 64-bit wrapping arithmetic
   function automatic comp_result_type compensate_press(logic [RAW_W-1:0] raw);
      comp_result_type r;
      logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic signed [63:0] v1, v2, p, num;
      p1 = {48'd0, press_cal_low[15:0]};
      p2 = 64'($signed(press_cal_low[31:16]));
      p3 = 64'($signed(press_cal_low[47:32]));
      p4 = 64'($signed(press_cal_low[63:48]));
      p5 = 64'($signed(press_cal_high[15:0]));
      p6 = 64'($signed(press_cal_high[31:16]));
      p7 = 64'($signed(press_cal_high[47:32]));
      p8 = 64'($signed(press_cal_high[63:48]));
      p9 = 64'($signed(press_cal_last));
      r = '0;
      v1 = 64'(fine_temp) - 64'sd128000;
      v2 = v1 * v1 * p6;
      v2 = v2 + ((v1 * p5) <<< 17);
      v2 = v2 + (p4 <<< 35);
      v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
      v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
      if (v1 == 0) begin
         r.zero_divisor = 1'b1;
      end else begin
         p = 64'sd1048576 - $signed({44'd0, raw});
         num = ((p <<< 31) - v2) * 64'sd3125;
         // quotient of the most negative value by -1 wraps
         p = (num == S64_MIN && v1 == -64'sd1) ? S64_MIN : num / v1;
         v1 = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
         v2 = (p8 * p) >>> 19;
         p = ((p + v1 + v2) >>> 8) + (p7 <<< 4);
         r.pressure_q24_8 = p[31:0];
      end
      return r;
   endfunction

   task automatic write_cal(logic [CSR_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      // block must be idle: all results back
      wait (expected_results.size() == 0);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_TEMP_CAL:       temp_cal = data[47:0];
         CSR_PRESS_CAL_LOW:  press_cal_low = data;
         CSR_PRESS_CAL_HIGH: press_cal_high = data;
         CSR_PRESS_CAL_LAST: press_cal_last = data[15:0];
      endcase
   endtask

   task automatic send_item(logic cmd, logic [RAW_W-1:0] raw, logic has_known,
                            comp_result_type known);
      int gap;
      comp_result_type pred;
      gap = idle_tx ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.command <= cmd;
      req_ch.raw_sample <= raw;
      do @(posedge clock); while (!req_ch.ready);
      pred = (cmd == CMD_TEMP) ? compensate_temp(raw) : compensate_press(raw);
      expected_results.push_back(has_known ? known : pred);
   endtask

   function automatic stim_row_type cfg_row(logic [CSR_IDX_W-1:0] idx, logic [63:0] data);
      stim_row_type s = '0;
      s.is_cfg = 1'b1;
      s.idx = idx;
      s.data = data;
      return s;
   endfunction

   function automatic stim_row_type item_row(logic cmd, logic [RAW_W-1:0] raw,
                                             logic has_known, comp_result_type known);
      stim_row_type s = '0;
      s.command = cmd;
      s.raw = raw;
      s.has_known = has_known;
      s.known = known;
      return s;
   endfunction

   // Stimulus: directed table, then random-item phases with varied calibration
   initial begin
      comp_result_type zero_res, div0_res;
      logic [63:0] cal_word;
      logic cmd;
      zero_res = '0;
      div0_res = '0;
      div0_res.zero_divisor = 1'b1;
      temp_cal = '0;
      press_cal_low = '0;
      press_cal_high = '0;
      press_cal_last = '0;
      fine_temp = '0;
      req_ch.valid = 1'b0;
      req_ch.command = CMD_TEMP;
      req_ch.raw_sample = '0;

      // after reset all calibration is zero: divisor zero, temperature zero
      directed_rows.push_back(item_row(CMD_PRESS, 20'h00000, 1'b1, div0_res));
      directed_rows.push_back(item_row(CMD_TEMP, 20'hFFFFF, 1'b1, zero_res));
      directed_rows.push_back(item_row(CMD_PRESS, 20'hFFFFF, 1'b1, div0_res));
      directed_rows.push_back(cfg_row(CSR_TEMP_CAL, {16'd0, TEMP_CAL_TYPICAL}));
      directed_rows.push_back(cfg_row(CSR_PRESS_CAL_LOW, PCAL_LOW_TYPICAL));
      directed_rows.push_back(cfg_row(CSR_PRESS_CAL_HIGH, PCAL_HIGH_TYPICAL));
      directed_rows.push_back(cfg_row(CSR_PRESS_CAL_LAST, {48'd0, PCAL_LAST_TYPICAL}));
      directed_rows.push_back(item_row(CMD_TEMP, 20'd519888, 1'b0, zero_res));
      directed_rows.push_back(item_row(CMD_PRESS, 20'd415148, 1'b0, zero_res));
      directed_rows.push_back(item_row(CMD_TEMP, 20'h00000, 1'b0, zero_res));
      directed_rows.push_back(item_row(CMD_PRESS, 20'h00000, 1'b0, zero_res));
      directed_rows.push_back(item_row(CMD_TEMP, 20'hFFFFF, 1'b0, zero_res));
      directed_rows.push_back(item_row(CMD_PRESS, 20'hFFFFF, 1'b0, zero_res));
      // all-ones calibration words
      directed_rows.push_back(cfg_row(CSR_TEMP_CAL, '1));
      directed_rows.push_back(cfg_row(CSR_PRESS_CAL_LOW, '1));
      directed_rows.push_back(cfg_row(CSR_PRESS_CAL_HIGH, '1));
      directed_rows.push_back(cfg_row(CSR_PRESS_CAL_LAST, '1));
      directed_rows.push_back(item_row(CMD_TEMP, 20'hFFFFF, 1'b0, zero_res));
      directed_rows.push_back(item_row(CMD_PRESS, 20'h80000, 1'b0, zero_res));
      directed_rows.push_back(item_row(CMD_PRESS, 20'h00000, 1'b0, zero_res));
      // P1 of zero forces a zero divisor
      directed_rows.push_back(cfg_row(CSR_PRESS_CAL_LOW, 64'h1234_5678_9ABC_0000));
      directed_rows.push_back(item_row(CMD_PRESS, 20'd12345, 1'b1, div0_res));
      directed_rows.push_back(item_row(CMD_TEMP, 20'h55555, 1'b0, zero_res));

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_cfg) begin
            req_ch.valid <= 1'b0;
            write_cal(directed_rows[i].idx, directed_rows[i].data);
         end else begin
            send_item(directed_rows[i].command, directed_rows[i].raw,
                      directed_rows[i].has_known, directed_rows[i].known);
         end
      end

      // hold off until the block has drained
      req_ch.valid <= 1'b0;
      wait (expected_results.size() == 0);

      for (int ph = 0; ph < 5; ph++) begin
         req_ch.valid <= 1'b0;
         // phase calibration: typical, random, or extreme
         case (ph % 3)
            0: begin
               write_cal(CSR_TEMP_CAL, {16'd0, TEMP_CAL_TYPICAL});
               write_cal(CSR_PRESS_CAL_LOW, PCAL_LOW_TYPICAL);
               write_cal(CSR_PRESS_CAL_HIGH, PCAL_HIGH_TYPICAL);
               write_cal(CSR_PRESS_CAL_LAST, {48'd0, PCAL_LAST_TYPICAL});
            end
            1: begin
               write_cal(CSR_TEMP_CAL, {$urandom, $urandom});
               write_cal(CSR_PRESS_CAL_LOW, {$urandom, $urandom});
               write_cal(CSR_PRESS_CAL_HIGH, {$urandom, $urandom});
               write_cal(CSR_PRESS_CAL_LAST, {$urandom, $urandom});
            end
            default: begin
               cal_word = (ph == 2) ? 64'h8000_8000_8000_8000 : 64'h7FFF_7FFF_7FFF_7FFF;
               write_cal(CSR_TEMP_CAL, cal_word);
               write_cal(CSR_PRESS_CAL_LOW, cal_word ^ 64'h0000_0000_0000_FFFF);
               write_cal(CSR_PRESS_CAL_HIGH, cal_word);
               write_cal(CSR_PRESS_CAL_LAST, cal_word);
            end
         endcase
         for (int n = 0; n < 86; n++) begin
            if (n % 30 == 0) begin
               idle_tx = $urandom_range(0, 2) != 0;
               idle_rx = $urandom_range(0, 2) != 0;
            end
            cmd = ($urandom_range(0, 1) == 0) ? CMD_TEMP : CMD_PRESS;
            send_item(cmd, 20'($urandom), 1'b0, zero_res);
         end
      end
      req_ch.valid <= 1'b0;

      wait (expected_results.size() == 0);
      repeat (200) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("barometric_sensor_compensation_tb: PASS");
      end else begin
         $display("barometric_sensor_compensation_tb: FAIL");
      end
      $finish;
   end

   // Result side: random stalls, compare with oldest expectation
   initial begin
      int stall;
      comp_result_type exp_res;
      rsp_ch.ready = 1'b0;
      forever begin
         stall = idle_rx ? $urandom_range(0, 4) : 0;
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && !reset));
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result item: temp %0d press %h flag %b",
                        $signed(rsp_ch.temperature_centi), rsp_ch.pressure_q24_8,
                        rsp_ch.zero_divisor);
         end else begin
            exp_res = expected_results.pop_front();
            if (rsp_ch.temperature_centi !== exp_res.temperature_centi ||
                rsp_ch.pressure_q24_8 !== exp_res.pressure_q24_8 ||
                rsp_ch.zero_divisor !== exp_res.zero_divisor) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: temp exp %0d got %0d, press exp %h got %h,",
                            " flag exp %b got %b"},
                           exp_res.temperature_centi, $signed(rsp_ch.temperature_centi),
                           exp_res.pressure_q24_8, rsp_ch.pressure_q24_8,
                           exp_res.zero_divisor, rsp_ch.zero_divisor);
            end
         end
      end
   end

endmodule

@@ sim.f @@
rtl/core/bsc_pkg.sv
rtl/core/bsc_if.sv
rtl/core/bsc_mul.sv
rtl/core/bsc_div.sv
rtl/core/barometric_sensor_compensation.sv
tb/barometric_sensor_compensation_tb.sv
